// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion shorthands for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define GRBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define GRBS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/grbs_pkg.sv =====
// ----------------------------------------------------------------------------
// grbs_pkg
// types, constants and register codes of the geometric ratio solver
// ----------------------------------------------------------------------------
package grbs_pkg;

  localparam int MAX_CELLS_DEF      = 1024;
  localparam int MAX_ITERATIONS_DEF = 32;

  localparam int LEN_W   = 32;  // Q16.16 lengths
  localparam int RATIO_W = 32;  // Q2.30 ratios
  localparam int CNT_IN_W = 11;
  localparam int ITER_W  = 7;
  localparam int T_W     = 34;  // horner sum, saturates at 2^33
  localparam int F_W     = 35;  // signed length error

  localparam logic [T_W-1:0] LEN_CAP = 34'h2_0000_0000;

  localparam logic [31:0] BRACKET_LOW_RST  = 32'd1074815566;
  localparam logic [31:0] BRACKET_HIGH_RST = 32'd1288490189;
  localparam logic [31:0] TOLERANCE_RST    = 32'd1;

  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_BRACKET_LOW  = 2'd0;
  localparam logic [1:0] REG_BRACKET_HIGH = 2'd1;
  localparam logic [1:0] REG_TOLERANCE    = 2'd2;

  typedef enum logic [1:0] {
    H_IDLE,
    H_LO,
    H_HI,
    H_ADD
  } horner_state_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_LAUNCH,
    C_EVAL,
    C_JUDGE,
    C_NEXT,
    C_FINISH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_LOW,
    PH_HIGH,
    PH_MID
  } phase_t;

  typedef struct packed {
    logic [31:0] bracket_low;
    logic [31:0] bracket_high;
    logic [31:0] tolerance;
  } cfg_regs_t;

  typedef struct packed {
    logic               start;
    logic [RATIO_W-1:0] q;
    logic [LEN_W-1:0]   a0;
  } horner_req_t;

  typedef struct packed {
    logic           done;
    logic [T_W-1:0] t;
  } horner_rsp_t;

endpackage

// ===== rtl/grbs_in_if.sv =====
// ----------------------------------------------------------------------------
// grbs_in_if
// input channel: first cell, total length and cell count
// ----------------------------------------------------------------------------
interface grbs_in_if;
  logic                          valid;
  logic                          ready;
  logic [grbs_pkg::LEN_W-1:0]    first_cell;
  logic [grbs_pkg::LEN_W-1:0]    total_length;
  logic [grbs_pkg::CNT_IN_W-1:0] cell_count;

  modport source (output valid, output first_cell, output total_length,
                  output cell_count, input ready);
  modport sink   (input valid, input first_cell, input total_length,
                  input cell_count, output ready);
endinterface

// ===== rtl/grbs_out_if.sv =====
// ----------------------------------------------------------------------------
// grbs_out_if
// result channel: ratio, status and iteration count
// ----------------------------------------------------------------------------
interface grbs_out_if;
  logic                         valid;
  logic                         ready;
  logic [grbs_pkg::RATIO_W-1:0] ratio;
  logic                         status;
  logic [grbs_pkg::ITER_W-1:0]  iteration_count;

  modport source (output valid, output ratio, output status,
                  output iteration_count, input ready);
  modport sink   (input valid, input ratio, input status,
                  input iteration_count, output ready);
endinterface

// ===== rtl/grbs_cfg.sv =====
// ----------------------------------------------------------------------------
// grbs_cfg
// apb register file: bracket ends and tolerance
// ----------------------------------------------------------------------------
module grbs_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [grbs_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output grbs_pkg::cfg_regs_t               regs
);

  logic [31:0] bracket_low_r;
  logic [31:0] bracket_high_r;
  logic [31:0] tolerance_r;
  logic        wr_en;
  logic [1:0]  idx;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bracket_low_r  <= grbs_pkg::BRACKET_LOW_RST;
      bracket_high_r <= grbs_pkg::BRACKET_HIGH_RST;
      tolerance_r    <= grbs_pkg::TOLERANCE_RST;
    end else if (wr_en) begin
      unique case (idx)
        grbs_pkg::REG_BRACKET_LOW:  bracket_low_r  <= pwdata;
        grbs_pkg::REG_BRACKET_HIGH: bracket_high_r <= pwdata;
        grbs_pkg::REG_TOLERANCE:    tolerance_r    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      grbs_pkg::REG_BRACKET_LOW:  prdata = bracket_low_r;
      grbs_pkg::REG_BRACKET_HIGH: prdata = bracket_high_r;
      grbs_pkg::REG_TOLERANCE:    prdata = tolerance_r;
      default:                    prdata = 32'd0;
    endcase
  end

  assign regs.bracket_low  = bracket_low_r;
  assign regs.bracket_high = bracket_high_r;
  assign regs.tolerance    = tolerance_r;

endmodule

// ===== rtl/grbs_horner.sv =====
// ----------------------------------------------------------------------------
// grbs_horner
// horner evaluation of a0*(1+q+...+q^(n-1)) on one 34x16 multiplier
// ----------------------------------------------------------------------------
module grbs_horner #(
  parameter int MAX_CELLS = grbs_pkg::MAX_CELLS_DEF,
  localparam int CntW = $clog2(MAX_CELLS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  grbs_pkg::horner_req_t   req,
  input  logic [CntW-1:0]         n,
  output grbs_pkg::horner_rsp_t   rsp
);

  localparam int T_W = grbs_pkg::T_W;

  grbs_pkg::horner_state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r;
  logic [T_W-1:0]  t_r;
  logic [T_W-1:0]  lo_r;
  logic [50:0]     sum_r;
  logic            done_r;

  logic [15:0]     mult_b;
  logic [49:0]     prod;
  logic [50:0]     sum;
  logic [37:0]     t_sum;
  logic [T_W-1:0]  t_clamp;
  logic [CntW-1:0] cnt_inc;
  logic            last_step;
  logic            finish;

  // low half of q first, then high half
  assign mult_b  = (state_r == grbs_pkg::H_HI) ? req.q[31:16] : req.q[15:0];
  assign prod    = 50'(t_r) * 50'(mult_b);
  assign sum     = 51'(prod) + 51'(lo_r);
  assign t_sum   = 38'(sum_r[50:14]) + 38'(req.a0);
  assign t_clamp = (t_sum > 38'(grbs_pkg::LEN_CAP)) ? grbs_pkg::LEN_CAP : t_sum[T_W-1:0];
  assign cnt_inc = cnt_r + CntW'(1);
  // saturation is sticky, so further steps cannot change the sum
  assign last_step = (cnt_inc == n) || (t_clamp == grbs_pkg::LEN_CAP);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      grbs_pkg::H_IDLE: begin
        if (req.start && (n != '0)) state_nxt = grbs_pkg::H_LO;
      end
      grbs_pkg::H_LO:  state_nxt = grbs_pkg::H_HI;
      grbs_pkg::H_HI:  state_nxt = grbs_pkg::H_ADD;
      grbs_pkg::H_ADD: state_nxt = last_step ? grbs_pkg::H_IDLE : grbs_pkg::H_LO;
      default:         state_nxt = grbs_pkg::H_IDLE;
    endcase
  end

  always_comb begin
    finish = 1'b0;
    unique case (state_r)
      grbs_pkg::H_IDLE: finish = req.start && (n == '0);
      grbs_pkg::H_ADD:  finish = last_step;
      default:          finish = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= grbs_pkg::H_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= finish;
      if (state_r == grbs_pkg::H_IDLE && req.start) cnt_r <= '0;
      else if (state_r == grbs_pkg::H_ADD)           cnt_r <= cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == grbs_pkg::H_IDLE && req.start) t_r <= '0;
    if (state_r == grbs_pkg::H_LO)  lo_r  <= prod[49:16];
    if (state_r == grbs_pkg::H_HI)  sum_r <= sum;
    if (state_r == grbs_pkg::H_ADD) t_r   <= t_clamp;
  end

  assign rsp.done = done_r;
  assign rsp.t    = t_r;

endmodule

// ===== rtl/grbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// grbs_ctrl
// bisection sequencer: bracket check, midpoint steps and result register
// ----------------------------------------------------------------------------
module grbs_ctrl #(
  parameter int MAX_CELLS      = grbs_pkg::MAX_CELLS_DEF,
  parameter int MAX_ITERATIONS = grbs_pkg::MAX_ITERATIONS_DEF,
  localparam int CntW  = $clog2(MAX_CELLS + 1),
  localparam int IterW = $clog2(MAX_ITERATIONS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  grbs_in_if.sink                in_ch,
  grbs_out_if.source             out_ch,
  input  grbs_pkg::cfg_regs_t    cfg,
  output grbs_pkg::horner_req_t  hreq,
  output logic [CntW-1:0]        n_eff,
  input  grbs_pkg::horner_rsp_t  hrsp
);

  localparam int F_W = grbs_pkg::F_W;

  grbs_pkg::ctrl_state_t state_r, state_nxt;
  grbs_pkg::phase_t      phase_r;

  logic [31:0]      a0_r, len_r;
  logic [CntW-1:0]  n_r;
  logic [31:0]      q1_r, q2_r, trial_q_r;
  logic [IterW-1:0] count_r;
  logic signed [F_W-1:0] f_r;
  logic             f1_neg_r, f1_pos_r;
  logic             err_r;
  logic             out_valid_r;
  logic [31:0]      out_ratio_r;
  logic             out_status_r;
  logic [grbs_pkg::ITER_W-1:0] out_iter_r;

  logic             accept;
  logic             out_free;
  logic [31:0]      n_ext;
  logic [CntW-1:0]  n_sat;
  logic             f_neg, f_zero, f_pos;
  logic [F_W-1:0]   f_abs;
  logic             in_tol;
  logic             same_sign;
  logic             opposite;
  logic [31:0]      gap;
  logic             stop_next;
  logic [32:0]      mid_sum;
  logic             launch;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign n_ext = 32'(in_ch.cell_count);
  assign n_sat = (n_ext > 32'(MAX_CELLS)) ? CntW'(MAX_CELLS) : CntW'(n_ext);

  assign f_neg    = f_r[F_W-1];
  assign f_zero   = (f_r == '0);
  assign f_pos    = !f_neg && !f_zero;
  assign f_abs    = f_neg ? F_W'(-f_r) : F_W'(f_r);
  assign in_tol   = f_abs <= F_W'(cfg.tolerance);
  // f1 and f2 share a strict sign
  assign same_sign = (f1_pos_r && f_pos) || (f1_neg_r && f_neg);
  assign opposite  = (f1_pos_r && f_neg) || (f1_neg_r && f_pos);

  assign gap       = (q2_r >= q1_r) ? (q2_r - q1_r) : (q1_r - q2_r);
  assign stop_next = (phase_r == grbs_pkg::PH_MID) &&
                     ((gap <= 32'd1) || (count_r == IterW'(MAX_ITERATIONS)));
  assign mid_sum   = 33'(q1_r) + 33'(q2_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      grbs_pkg::C_IDLE:   if (accept) state_nxt = grbs_pkg::C_LAUNCH;
      grbs_pkg::C_LAUNCH: state_nxt = grbs_pkg::C_EVAL;
      grbs_pkg::C_EVAL:   if (hrsp.done) state_nxt = grbs_pkg::C_JUDGE;
      grbs_pkg::C_JUDGE: begin
        unique case (phase_r)
          grbs_pkg::PH_LOW:  state_nxt = grbs_pkg::C_LAUNCH;
          grbs_pkg::PH_HIGH: state_nxt = same_sign ? grbs_pkg::C_FINISH : grbs_pkg::C_NEXT;
          grbs_pkg::PH_MID:  state_nxt = in_tol ? grbs_pkg::C_FINISH : grbs_pkg::C_NEXT;
          default:           state_nxt = grbs_pkg::C_FINISH;
        endcase
      end
      grbs_pkg::C_NEXT:   state_nxt = stop_next ? grbs_pkg::C_FINISH : grbs_pkg::C_LAUNCH;
      grbs_pkg::C_FINISH: if (out_free) state_nxt = grbs_pkg::C_IDLE;
      default:            state_nxt = grbs_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == grbs_pkg::C_IDLE);
    launch      = (state_r == grbs_pkg::C_LAUNCH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grbs_pkg::C_IDLE;
      phase_r     <= grbs_pkg::PH_LOW;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) phase_r <= grbs_pkg::PH_LOW;
      else if (state_r == grbs_pkg::C_JUDGE && phase_r == grbs_pkg::PH_LOW)
        phase_r <= grbs_pkg::PH_HIGH;
      else if (state_r == grbs_pkg::C_NEXT)
        phase_r <= grbs_pkg::PH_MID;
      if (state_r == grbs_pkg::C_FINISH && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)                          out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a0_r      <= in_ch.first_cell;
      len_r     <= in_ch.total_length;
      n_r       <= n_sat;
      q1_r      <= cfg.bracket_low;
      q2_r      <= cfg.bracket_high;
      trial_q_r <= cfg.bracket_low;
      count_r   <= '0;
      err_r     <= 1'b0;
    end
    if (state_r == grbs_pkg::C_EVAL && hrsp.done)
      f_r <= $signed({1'b0, hrsp.t}) - $signed({3'b000, len_r});
    if (state_r == grbs_pkg::C_JUDGE) begin
      unique case (phase_r)
        grbs_pkg::PH_LOW: begin
          f1_neg_r  <= f_neg;
          f1_pos_r  <= f_pos;
          trial_q_r <= q2_r;
        end
        grbs_pkg::PH_HIGH: begin
          if (same_sign) err_r <= 1'b1;
        end
        grbs_pkg::PH_MID: begin
          if (!in_tol) begin
            if (opposite) begin
              q2_r <= trial_q_r;
            end else begin
              q1_r     <= trial_q_r;
              f1_neg_r <= f_neg;
              f1_pos_r <= f_pos;
            end
          end
        end
        default: ;
      endcase
    end
    if (state_r == grbs_pkg::C_NEXT && !stop_next) begin
      trial_q_r <= mid_sum[32:1];
      count_r   <= count_r + IterW'(1);
    end
    if (state_r == grbs_pkg::C_FINISH && out_free) begin
      out_ratio_r  <= err_r ? 32'd0 : trial_q_r;
      out_status_r <= err_r;
      out_iter_r   <= err_r ? '0 : grbs_pkg::ITER_W'(count_r);
    end
  end

  assign hreq.start = launch;
  assign hreq.q     = trial_q_r;
  assign hreq.a0    = a0_r;
  assign n_eff      = n_r;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.ratio           = out_ratio_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.iteration_count = out_iter_r;

endmodule

// ===== rtl/geometric_ratio_bisection_solver_core.sv =====
// ----------------------------------------------------------------------------
// geometric_ratio_bisection_solver_core
// bisection solver for the expansion ratio of a geometric cell progression
// ----------------------------------------------------------------------------
// in_if carries one beat of first_cell, total_length and cell_count; out_if
// returns one beat of ratio, status and iteration_count for each input beat.
// The cfg_ apb port holds bracket_low (0x0), bracket_high (0x4) and
// tolerance (0x8); write it only while no item is in flight.
// One horner step runs H_LO and H_HI, the two partial products on the shared
// 34x16 multiplier, and then H_ADD, the sum. An item evaluates both bracket
// ends and then up to MAX_ITERATIONS midpoints; a saturated sum ends an
// evaluation early.
// in_if.ready is high only while no item is being solved. The result waits
// in an output register, so a new item is accepted while out_if is stalled;
// the next result holds in its final state until that register frees.
// rst_n (synchronous) empties the block and restores the register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module geometric_ratio_bisection_solver_core #(
  parameter int MAX_CELLS      = grbs_pkg::MAX_CELLS_DEF,
  parameter int MAX_ITERATIONS = grbs_pkg::MAX_ITERATIONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  grbs_in_if.sink                          in_if,
  grbs_out_if.source                       out_if,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [grbs_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  localparam int CntW = $clog2(MAX_CELLS + 1);

  grbs_pkg::cfg_regs_t   cfg_regs;
  grbs_pkg::horner_req_t hreq;
  grbs_pkg::horner_rsp_t hrsp;
  logic [CntW-1:0]       n_eff;

  grbs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (cfg_regs)
  );

  grbs_horner #(
    .MAX_CELLS (MAX_CELLS)
  ) u_horner (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .n     (n_eff),
    .rsp   (hrsp)
  );

  grbs_ctrl #(
    .MAX_CELLS      (MAX_CELLS),
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg    (cfg_regs),
    .hreq   (hreq),
    .n_eff  (n_eff),
    .hrsp   (hrsp)
  );

  // an accepted beat keeps the solver busy
  `GRBS_ASSERT_NXT(a_busy_after_accept, in_if.valid && in_if.ready, !in_if.ready, "ready after accept")
  // evaluations start only while an item is in flight
  `GRBS_ASSERT_IMP(a_start_busy, hreq.start, !in_if.ready, "horner start while idle")
  // a bracket error reports zero ratio and zero steps
  `GRBS_ASSERT_IMP(a_err_result, out_if.valid && out_if.status, (out_if.ratio == 32'd0) && (out_if.iteration_count == '0), "bad error result")
  // step count never passes the limit
  `GRBS_ASSERT_IMP(a_iter_limit, out_if.valid, out_if.iteration_count <= grbs_pkg::ITER_W'(MAX_ITERATIONS), "step count above limit")

endmodule
